// ===== hdl/mpm_pkg.sv =====
// package for the message pool and mailbox block
// types, codes and defaults shared by the top level; no dependencies
`timescale 1ns / 1ps
package mpm_pkg;
  localparam int NUM_MSGS_DEF   = 64;
  localparam int NUM_QUEUES_DEF = 16;
  localparam int ACT_W    = 3;
  localparam int QID_W    = 4;
  localparam int MIDX_W   = 6;
  localparam int SND_W    = 8;
  localparam int PAY_W    = 32;
  localparam int STAT_W   = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC  = 3'd0,
    ACT_FREE   = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_PUSH   = 3'd3,
    ACT_POP    = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EXH   = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_ALLOC_RD, S_WALK_RD, S_WALK_CHK,
    S_POP_UNLINK, S_CLEAR_RD, S_CLEAR_STEP, S_TAIL_LINK, S_REPORT, S_OUT
  } fsm_t;
endpackage

// ===== hdl/message_pool_and_mailboxes_top.sv =====
// message pool with free list and per-queue mailboxes, top level
// slot memories, queue head/tail registers and the sequencer; uses mpm_pkg
//
// One input beat is one operation (alloc, free, insert tail, push head, pop,
// clear); each gives exactly one result beat with status, popped slot data
// and the addressed queue's empty flag and head.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Slot sender, payload, link and held flag live in synchronous memories
// (registered read). Push and any operation that changes no list pass from
// dispatch straight to report; alloc adds a free-list read, and free or insert
// onto a non-empty list adds a tail link write. Pop walks the queue one entry
// at a time (up to NUM_MSGS entries) and unlinks the first match; clear walks
// every entry of the queue. One operation is in flight at a time; the next
// input can be taken in the cycle after the result beat leaves.
// After reset an init pass over every slot writes the link memory as an
// ordered free chain and zeroes sender, payload and held flag; no input beat
// is taken meanwhile. A finished result waits in the output register while the
// receiver stalls; the next input is taken only once it has left.
`timescale 1ns / 1ps
module message_pool_and_mailboxes_top #(
  parameter int NUM_MSGS   = mpm_pkg::NUM_MSGS_DEF,
  parameter int NUM_QUEUES = mpm_pkg::NUM_QUEUES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [mpm_pkg::ACT_W-1:0]  action,
  input  logic [mpm_pkg::QID_W-1:0]  queue_id,
  input  logic [mpm_pkg::MIDX_W-1:0] msg_index,
  input  logic [mpm_pkg::SND_W-1:0]  sender_id,
  input  logic                       any_sender,
  input  logic [mpm_pkg::PAY_W-1:0]  payload_in,
  output logic out_valid,
  input  logic out_stall,
  output logic [mpm_pkg::STAT_W-1:0] status,
  output logic [mpm_pkg::MIDX_W-1:0] msg_out,
  output logic [mpm_pkg::SND_W-1:0]  sender_out,
  output logic [mpm_pkg::PAY_W-1:0]  payload_out,
  output logic                       queue_empty,
  output logic [mpm_pkg::MIDX_W-1:0] head_msg
);
  import mpm_pkg::*;

  localparam int SW = $clog2(NUM_MSGS);
  localparam int PW = SW + 1;
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [PW-1:0] NIL = PW'(NUM_MSGS);
  localparam logic [PW-1:0] LAST = PW'(NUM_MSGS - 1);

  // slot memories
  logic [SND_W-1:0] mem_snd  [NUM_MSGS];
  logic [PAY_W-1:0] mem_pay  [NUM_MSGS];
  logic [PW-1:0]    mem_nxt  [NUM_MSGS];
  logic             mem_held [NUM_MSGS];

  logic [PW-1:0] q_head [NUM_QUEUES];
  logic [PW-1:0] q_tail [NUM_QUEUES];
  logic [PW-1:0] free_head, free_tail;

  fsm_t state, state_next;

  // latched operation
  action_t          op;
  logic [QID_W-1:0] r_q;
  logic [MIDX_W-1:0] r_m;
  logic [SND_W-1:0] r_snd;
  logic             r_any;
  logic [PAY_W-1:0] r_pay;
  logic [PW-1:0]    cur, prev, steps;
  logic [SW-1:0]    init_cnt;

  // memory read port
  logic [SW-1:0]    rd_addr;
  logic [SND_W-1:0] rd_snd;
  logic [PAY_W-1:0] rd_pay;
  logic [PW-1:0]    rd_nxt;
  logic             rd_held;

  // write ports, link memory, data memories and held flags separately
  logic             nw_en, dw_en, hw_en;
  logic [SW-1:0]    nw_addr, dw_addr, hw_addr;
  logic [PW-1:0]    nw_data;
  logic [SND_W-1:0] dw_snd;
  logic [PAY_W-1:0] dw_pay;
  logic             hw_data;

  logic [QW-1:0] qi;
  logic qok, mok, accept, out_take;
  logic [PW-1:0] qh, qt;

  assign qi   = QW'(r_q);
  assign qok  = 32'(r_q) < NUM_QUEUES;
  assign qh   = qok ? q_head[qi] : NIL;
  assign qt   = qok ? q_tail[qi] : NIL;
  assign mok  = (32'(r_m) < NUM_MSGS) && rd_held;
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (nw_en) mem_nxt[nw_addr] <= nw_data;
    if (dw_en) begin
      mem_snd[dw_addr] <= dw_snd;
      mem_pay[dw_addr] <= dw_pay;
    end
    if (hw_en) mem_held[hw_addr] <= hw_data;
    rd_nxt  <= mem_nxt[rd_addr];
    rd_snd  <= mem_snd[rd_addr];
    rd_pay  <= mem_pay[rd_addr];
    rd_held <= mem_held[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT:     if (32'(init_cnt) == NUM_MSGS - 1) state_next = S_IDLE;
      S_IDLE:     if (accept) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (op)
          ACT_ALLOC:  state_next = (free_head >= NIL) ? S_REPORT : S_ALLOC_RD;
          ACT_FREE:   state_next = (mok && free_head < NIL) ? S_TAIL_LINK : S_REPORT;
          ACT_INSERT: state_next = (mok && qok && qh < NIL) ? S_TAIL_LINK : S_REPORT;
          ACT_POP:    state_next = (qh < NIL) ? S_WALK_RD : S_REPORT;
          ACT_CLEAR:  state_next = (qh < NIL) ? S_CLEAR_RD : S_REPORT;
          default:    state_next = S_REPORT;
        endcase
      end
      S_ALLOC_RD:   state_next = S_REPORT;
      S_WALK_RD:    state_next = S_WALK_CHK;
      S_WALK_CHK: begin
        if (r_any || rd_snd == r_snd) state_next = S_POP_UNLINK;
        else if (rd_nxt >= NIL || steps == LAST) state_next = S_REPORT;
        else state_next = S_WALK_RD;
      end
      S_POP_UNLINK: state_next = S_REPORT;
      S_CLEAR_RD:   state_next = S_CLEAR_STEP;
      S_CLEAR_STEP: begin
        if (rd_nxt >= NIL || steps == LAST) state_next = S_REPORT;
        else state_next = S_CLEAR_RD;
      end
      S_TAIL_LINK:  state_next = S_REPORT;
      S_REPORT:     state_next = S_OUT;
      S_OUT:        if (out_take) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    rd_addr = cur[SW-1:0];
    nw_en = 1'b0; nw_addr = '0; nw_data = NIL;
    dw_en = 1'b0; dw_addr = '0; dw_snd = '0; dw_pay = '0;
    hw_en = 1'b0; hw_addr = '0; hw_data = 1'b0;
    case (state)
      S_INIT: begin
        nw_en = 1'b1; nw_addr = init_cnt; nw_data = PW'(init_cnt) + PW'(1);
        dw_en = 1'b1; dw_addr = init_cnt;
        hw_en = 1'b1; hw_addr = init_cnt;
      end
      // fetch the held flag of the addressed slot while waiting
      S_IDLE: rd_addr = SW'(msg_index);
      S_DISPATCH: begin
        case (op)
          ACT_ALLOC: begin
            rd_addr = free_head[SW-1:0];
            if (free_head < NIL) begin
              dw_en = 1'b1; dw_addr = free_head[SW-1:0];
              hw_en = 1'b1; hw_addr = free_head[SW-1:0]; hw_data = 1'b1;
            end
          end
          ACT_FREE: if (mok) begin
            nw_en = 1'b1; nw_addr = SW'(r_m); nw_data = NIL;
            hw_en = 1'b1; hw_addr = SW'(r_m);
          end
          ACT_INSERT, ACT_PUSH: if (mok && qok) begin
            nw_en = 1'b1; nw_addr = SW'(r_m);
            nw_data = (op == ACT_PUSH) ? qh : NIL;
            dw_en = 1'b1; dw_addr = SW'(r_m); dw_snd = r_snd; dw_pay = r_pay;
            hw_en = 1'b1; hw_addr = SW'(r_m);
          end
          default: ;
        endcase
      end
      S_ALLOC_RD: begin
        nw_en = 1'b1; nw_addr = free_head[SW-1:0]; nw_data = NIL;
      end
      S_TAIL_LINK: begin
        nw_en = 1'b1; nw_addr = (op == ACT_FREE) ? free_tail[SW-1:0] : qt[SW-1:0];
        nw_data = PW'(r_m);
      end
      S_WALK_CHK: if (r_any || rd_snd == r_snd) begin
        if (prev < NIL) begin
          nw_en = 1'b1; nw_addr = prev[SW-1:0]; nw_data = rd_nxt;
        end
        hw_en = 1'b1; hw_addr = cur[SW-1:0]; hw_data = 1'b1;
      end
      S_POP_UNLINK: begin
        nw_en = 1'b1; nw_addr = cur[SW-1:0]; nw_data = NIL;
      end
      S_CLEAR_STEP: begin
        nw_en = 1'b1; nw_addr = cur[SW-1:0]; nw_data = NIL;
        hw_en = 1'b1; hw_addr = cur[SW-1:0]; hw_data = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers and list pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      init_cnt <= '0;
      free_head <= '0;
      free_tail <= LAST;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        q_head[i] <= NIL;
        q_tail[i] <= NIL;
      end
    end else begin
      state <= state_next;
      case (state)
        S_INIT: init_cnt <= init_cnt + SW'(1);
        S_IDLE: if (accept) begin
          op <= action_t'(action);
          r_q <= queue_id; r_m <= msg_index; r_snd <= sender_id;
          r_any <= any_sender; r_pay <= payload_in;
          status <= ST_OK; msg_out <= '0; sender_out <= '0; payload_out <= '0;
        end
        S_DISPATCH: begin
          cur <= qh; prev <= NIL; steps <= '0;
          case (op)
            ACT_ALLOC: if (free_head >= NIL) status <= ST_EXH;
              else msg_out <= MIDX_W'(free_head);
            // empty list takes the slot as head and tail; else tail moves on link
            ACT_FREE: if (mok && free_head >= NIL) begin
              free_head <= PW'(r_m);
              free_tail <= PW'(r_m);
            end
            ACT_INSERT: if (mok && qok && qh >= NIL) begin
              q_head[qi] <= PW'(r_m);
              q_tail[qi] <= PW'(r_m);
            end
            ACT_PUSH: if (mok && qok) begin
              if (qh >= NIL) q_tail[qi] <= PW'(r_m);
              q_head[qi] <= PW'(r_m);
            end
            ACT_POP: if (qh >= NIL) status <= ST_EMPTY;
            ACT_CLEAR: if (qok) begin
              q_head[qi] <= NIL;
              q_tail[qi] <= NIL;
            end
            default: ;
          endcase
        end
        S_ALLOC_RD: begin
          free_head <= rd_nxt;
          if (rd_nxt >= NIL) free_tail <= NIL;
        end
        S_TAIL_LINK: begin
          if (op == ACT_FREE) free_tail <= PW'(r_m);
          else q_tail[qi] <= PW'(r_m);
        end
        S_WALK_CHK: begin
          if (r_any || rd_snd == r_snd) begin
            if (prev >= NIL) q_head[qi] <= rd_nxt;
            if (qt == cur) q_tail[qi] <= prev;
            else if (prev >= NIL && rd_nxt >= NIL) q_tail[qi] <= NIL;
            msg_out <= MIDX_W'(cur);
            sender_out <= rd_snd;
            payload_out <= rd_pay;
          end else begin
            if (rd_nxt >= NIL || steps == LAST) status <= ST_EMPTY;
            prev <= cur;
            cur <= rd_nxt;
            steps <= steps + PW'(1);
          end
        end
        S_CLEAR_STEP: begin
          cur <= rd_nxt;
          steps <= steps + PW'(1);
        end
        S_REPORT: begin
          queue_empty <= !(qh < NIL);
          head_msg <= (qh < NIL) ? MIDX_W'(qh) : '0;
          out_valid <= 1'b1;
        end
        S_OUT: if (out_take) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  // checks
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result outside output state");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_free_tail: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && free_head >= NIL) |-> free_tail >= NIL)
    else $error("free tail set on empty free list");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3) else $error("bad status code");
endmodule
